>>> hw/rtl/crc_checked_flow_pi_regulator_top_assert.svh
// assertion macros for the flow regulator
`ifndef CRC_CHECKED_FLOW_PI_REGULATOR_TOP_ASSERT_SVH
`define CRC_CHECKED_FLOW_PI_REGULATOR_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define CFPI_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define CFPI_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/crcfpi_pkg.sv
package crcfpi_pkg;

	localparam int DUTY_BITS_DEF = 12;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [15:0] FLOW_COEF = 16'd43962;
	localparam logic [12:0] TARGET_MAX = 13'd6400;
	localparam logic [14:0] FLOW_MAX = 15'd31085;

	localparam int CFG_IDX_BITS = 3;
	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_PGAIN = 3'd1;
	localparam logic [2:0] REG_IGAIN = 3'd2;
	localparam logic [2:0] REG_ILIMIT = 3'd3;

	typedef enum logic [1:0] {MUL_FLOW, MUL_PROP, MUL_ILO, MUL_IHI} mul_sel_t;
	typedef enum logic [1:0] {SUM_NONE, SUM_LOAD, SUM_ADD, SUM_ADD_HI} sum_op_t;

	typedef struct packed {
		logic     load;
		logic     root_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     hold_wr;
		logic     err_en;
		sum_op_t  sum_op;
		logic     out_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_ok;
	} dp_stat_t;

	function automatic logic [7:0] crc_word(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] c;
		logic [15:0] d;
		c = 8'h00;
		d = {hi, lo};
		for (int i = 0; i < 16; i++) begin
			if (i == 0 || i == 8)
				c = c ^ ((i == 0) ? d[15:8] : d[7:0]);
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/crcfpi_ctrl.sv
module crcfpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  crcfpi_pkg::dp_stat_t stat,
	output crcfpi_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROOT, ST_SCALE, ST_HOLD, ST_ERR,
		ST_MP, ST_MI0, ST_MI1, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [3:0] cnt_q;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.mul_sel = crcfpi_pkg::MUL_FLOW;
		cmd.sum_op = crcfpi_pkg::SUM_NONE;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_ROOT:  cmd.root_step = 1'b1;
			ST_SCALE: cmd.mul_en = 1'b1;
			ST_HOLD:  cmd.hold_wr = 1'b1;
			ST_ERR:   cmd.err_en = 1'b1;
			ST_MP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = crcfpi_pkg::MUL_PROP;
			end
			ST_MI0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = crcfpi_pkg::MUL_ILO;
				cmd.sum_op = crcfpi_pkg::SUM_LOAD;
			end
			ST_MI1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = crcfpi_pkg::MUL_IHI;
				cmd.sum_op = crcfpi_pkg::SUM_ADD;
			end
			ST_FIN:   cmd.sum_op = crcfpi_pkg::SUM_ADD_HI;
			ST_OUT:   cmd.out_wr = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_wr)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (!stat.frame_ok)
						state_q <= ST_ERR;
					else if (cnt_q == 4'd15)
						state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_HOLD;
				ST_HOLD:  state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_MP;
				ST_MP:    state_q <= ST_MI0;
				ST_MI0:   state_q <= ST_MI1;
				ST_MI1:   state_q <= ST_FIN;
				ST_FIN:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/crcfpi_dp.sv
module crcfpi_dp #(
	parameter int DUTY_BITS = crcfpi_pkg::DUTY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic [7:0]            press_high,
	input  logic [7:0]            press_low,
	input  logic [7:0]            press_crc,
	input  logic [7:0]            temp_high,
	input  logic [7:0]            temp_low,
	input  logic [7:0]            temp_crc,
	input  logic [7:0]            third_high,
	input  logic [7:0]            third_low,
	input  logic [7:0]            third_crc,
	input  crcfpi_pkg::dp_cmd_t   cmd,
	output crcfpi_pkg::dp_stat_t  stat,
	output logic [DUTY_BITS-1:0]  duty,
	output logic [14:0]           flow_now,
	output logic                  frame_ok
);

	localparam logic [41:0] DUTY_MAX = 42'((64'd1 << DUTY_BITS) - 64'd1);

	logic [12:0] target_q;
	logic [23:0] pgain_q, igain_q;
	logic [30:0] ilimit_q;
	logic [14:0] held_q;
	logic signed [31:0] integ_q;
	logic ok_q;
	logic [31:0] rem_q, res_q, bit_q;
	logic signed [15:0] err_q;
	logic signed [41:0] prod_q;
	logic signed [57:0] sum_q;

	logic frame_good;
	logic [31:0] trial;
	logic signed [24:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [15:0] err_c;
	logic signed [32:0] acc_c, lim_c;
	logic signed [41:0] sum_hi;
	logic [DUTY_BITS-1:0] duty_c;

	assign frame_good = (crcfpi_pkg::crc_word(press_high, press_low) == press_crc)
		&& (crcfpi_pkg::crc_word(temp_high, temp_low) == temp_crc)
		&& (crcfpi_pkg::crc_word(third_high, third_low) == third_crc);
	assign stat.frame_ok = ok_q;
	assign trial = res_q + bit_q;

	always_comb begin
		unique case (cmd.mul_sel)
			crcfpi_pkg::MUL_FLOW: begin
				mul_a = {9'd0, res_q[15:0]};
				mul_b = {1'b0, crcfpi_pkg::FLOW_COEF};
			end
			crcfpi_pkg::MUL_PROP: begin
				mul_a = {1'b0, pgain_q};
				mul_b = {err_q[15], err_q};
			end
			crcfpi_pkg::MUL_ILO: begin
				mul_a = {1'b0, igain_q};
				mul_b = {1'b0, integ_q[15:0]};
			end
			crcfpi_pkg::MUL_IHI: begin
				mul_a = {1'b0, igain_q};
				mul_b = {integ_q[31], integ_q[31:16]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign err_c = $signed({3'b000, target_q}) - $signed({1'b0, held_q});
	assign acc_c = 33'(integ_q) + 33'(err_c);
	assign lim_c = $signed({2'b00, ilimit_q});
	assign sum_hi = 42'(sum_q >>> 16);

	always_comb begin
		if (sum_q <= 58'sd0)
			duty_c = '0;
		else if (sum_hi > $signed(DUTY_MAX))
			duty_c = DUTY_MAX[DUTY_BITS-1:0];
		else
			duty_c = sum_hi[DUTY_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			pgain_q <= '0;
			igain_q <= '0;
			ilimit_q <= '0;
			held_q <= '0;
			integ_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					crcfpi_pkg::REG_TARGET: target_q <= (cfg_data[12:0] > crcfpi_pkg::TARGET_MAX)
						? crcfpi_pkg::TARGET_MAX : cfg_data[12:0];
					crcfpi_pkg::REG_PGAIN:  pgain_q <= cfg_data[23:0];
					crcfpi_pkg::REG_IGAIN:  igain_q <= cfg_data[23:0];
					crcfpi_pkg::REG_ILIMIT: ilimit_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (cmd.hold_wr)
				held_q <= prod_q[30:16];
			if (cmd.err_en) begin
				if (acc_c > lim_c)
					integ_q <= lim_c[31:0];
				else if (acc_c < -lim_c)
					integ_q <= 32'(-lim_c);
				else
					integ_q <= acc_c[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q <= frame_good;
			rem_q <= press_high[7] ? 32'd0 : {press_high, press_low, 16'd0};
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end
		if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.err_en)
			err_q <= err_c;
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		unique case (cmd.sum_op)
			crcfpi_pkg::SUM_NONE:   ;
			crcfpi_pkg::SUM_LOAD:   sum_q <= 58'(prod_q);
			crcfpi_pkg::SUM_ADD:    sum_q <= sum_q + 58'(prod_q);
			crcfpi_pkg::SUM_ADD_HI: sum_q <= sum_q + (58'(prod_q) <<< 16);
			default: ;
		endcase
		if (cmd.out_wr) begin
			duty <= duty_c;
			flow_now <= held_q;
			frame_ok <= ok_q;
		end
	end

endmodule

>>> hw/rtl/crc_checked_flow_pi_regulator_top.sv
// channel  | handshake              | words
// in       | in_valid / in_stall    | nine frame bytes
// out      | out_valid / out_stall  | duty, flow_now, frame_ok
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
// A frame with good CRCs runs the 16-step square root loop, then scale, hold,
// error, PI and out states; a failed CRC jumps from the loop to the error state.
// One 25x17 multiplier is shared by flow scaling and the three PI products.
// Reset clears config registers, held flow and integral; no clearing pass.
// The result register lets the next frame in while out is stalled.
module crc_checked_flow_pi_regulator_top #(
	parameter int DUTY_BITS = crcfpi_pkg::DUTY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           press_high,
	input  logic [7:0]           press_low,
	input  logic [7:0]           press_crc,
	input  logic [7:0]           temp_high,
	input  logic [7:0]           temp_low,
	input  logic [7:0]           temp_crc,
	input  logic [7:0]           third_high,
	input  logic [7:0]           third_low,
	input  logic [7:0]           third_crc,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DUTY_BITS-1:0] duty,
	output logic [14:0]          flow_now,
	output logic                 frame_ok
);

	`include "crc_checked_flow_pi_regulator_top_assert.svh"

	crcfpi_pkg::dp_cmd_t cmd;
	crcfpi_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	crcfpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	crcfpi_dp #(.DUTY_BITS(DUTY_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.press_high (press_high),
		.press_low  (press_low),
		.press_crc  (press_crc),
		.temp_high  (temp_high),
		.temp_low   (temp_low),
		.temp_crc   (temp_crc),
		.third_high (third_high),
		.third_low  (third_low),
		.third_crc  (third_crc),
		.cmd        (cmd),
		.stat       (stat),
		.duty       (duty),
		.flow_now   (flow_now),
		.frame_ok   (frame_ok)
	);

	`CFPI_ASSERT(a_flow_range, !out_valid || flow_now <= crcfpi_pkg::FLOW_MAX, "flow out of range")
	`CFPI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "frame not held off")

endmodule
